// ----- hw/rtl/cpct_pkg.sv -----
package cpct_pkg;

    typedef enum logic [2:0] {
        MODE_RESET     = 3'd0,
        MODE_CHECK     = 3'd1,
        MODE_BYTE      = 3'd2,
        MODE_IDENTITY  = 3'd3,
        MODE_CTL_RESET = 3'd4,
        MODE_POLL      = 3'd5,
        MODE_ACC_READ  = 3'd6,
        MODE_ACC_WRITE = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_PARTIAL   = 3'd1,
        STS_FULL      = 3'd2,
        STS_BAD_READ  = 3'd3,
        STS_BAD_WRITE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SEND_NONE    = 3'd0,
        SEND_CMD     = 3'd1,
        SEND_DEFAULT = 3'd2,
        SEND_PROBE   = 3'd3,
        SEND_ACK     = 3'd4
    } send_kind_t;

    typedef enum logic [1:0] {
        HS_IDENTITY = 2'd0,
        HS_RUMBLE   = 2'd1,
        HS_STREAM   = 2'd2,
        HS_IDLE     = 2'd3
    } hs_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COMMIT
    } ctl_state_t;

    localparam logic [6:0]  READ_LENGTH   = 7'h03;
    localparam logic [6:0]  WRITE_LENGTH  = 7'h23;
    localparam logic [10:0] PROBE_ADDRESS = 11'h400;
    localparam logic [10:0] RUMBLE_ADDRESS = 11'h600;
    localparam logic [7:0]  RUMBLE_EXTRA_MASK = 8'hFE;
    localparam logic [1:0]  RESET_PLAYER  = 2'd3;
    localparam logic [2:0]  STREAM_PLAYER = 3'd3;
    localparam logic [3:0]  REPORT_SET    = 4'h7;

    typedef struct packed {
        logic       load;
        logic       rd_issue;
        logic [1:0] rd_idx;
        logic       capture;
        logic       commit;
    } cpct_cmd_t;

    typedef struct packed {
        logic stream;
    } cpct_sts_t;

endpackage

// ----- hw/rtl/cpct_ctl.sv -----
module cpct_ctl
    import cpct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  cpct_sts_t sts,
    output cpct_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.stream)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_idx   = 2'd0;
                    cnt_next     = 2'd0;
                    state_next   = ST_READ;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_idx   = cnt_reg + 2'd1;
                    cnt_next     = cnt_reg + 2'd1;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
        out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    end

endmodule

// ----- hw/rtl/cpct_dp.sv -----
module cpct_dp
    import cpct_pkg::*;
#(
    parameter int SLOT_COUNT    = 16,
    parameter int COMMAND_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cpct_cmd_t   cmd,
    output cpct_sts_t   sts,
    input  logic [2:0]  mode,
    input  logic [2:0]  player,
    input  logic [7:0]  host_byte,
    input  logic [6:0]  request_length,
    input  logic [15:0] accessory_address,
    input  logic        address_crc_ok,
    input  logic [7:0]  write_first_byte,
    output logic [2:0]  status,
    output logic        command_complete,
    output logic [2:0]  send_kind,
    output logic [31:0] send_word,
    output logic        address_crc_error,
    output logic        rumble_value_error,
    output logic        rumble_report_valid,
    output logic [3:0]  rumble_report
);

    localparam int DEPTH = SLOT_COUNT * COMMAND_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int FW    = $clog2(SLOT_COUNT + 1);
    localparam int OW    = $clog2(COMMAND_BYTES);
    localparam int OXW   = $clog2(COMMAND_BYTES + 4);

    logic [7:0] mem [0:DEPTH-1];

    mode_t       mode_reg;
    logic [2:0]  player_reg;
    logic [7:0]  host_byte_reg;
    logic [6:0]  request_length_reg;
    logic [15:0] accessory_address_reg;
    logic        address_crc_ok_reg;
    logic [7:0]  write_first_byte_reg;

    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [FW-1:0] slots_filled_reg, slots_filled_next;
    logic [OW-1:0] write_offset_reg, write_offset_next;
    logic [OW-1:0] read_offset_reg, read_offset_next;
    logic [1:0]    expected_player_reg, expected_player_next;
    hs_t           hs_reg, hs_next;
    logic [3:0]    rumble_seen_reg, rumble_seen_next;
    logic [3:0]    rumble_bits_reg, rumble_bits_next;

    logic [7:0]  rdata_reg;
    logic        beyond_reg;
    logic [31:0] word_reg;

    status_t    status_reg, status_next;
    logic       complete_reg, complete_next;
    send_kind_t kind_reg, kind_next;
    logic [31:0] word_out_reg, word_out_next;
    logic       crc_err_reg, crc_err_next;
    logic       val_err_reg, val_err_next;
    logic       rep_valid_reg, rep_valid_next;
    logic [3:0] report_reg, report_next;

    logic          match, filled_nz, full, enter, stream;
    logic [OW-1:0] eff_off;
    logic [OXW-1:0] off_sum, wr_off_inc, rd_off;
    logic          rd_beyond;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [1:0]    next_ply;
    logic [3:0]    pbit, seen_base, bits_base, seen_new, bits_new;
    logic          mem_we;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg              <= mode_t'(mode);
            player_reg            <= player;
            host_byte_reg         <= host_byte;
            request_length_reg    <= request_length;
            accessory_address_reg <= accessory_address;
            address_crc_ok_reg    <= address_crc_ok;
            write_first_byte_reg  <= write_first_byte;
        end
    end

    assign match     = ({1'b0, expected_player_reg} == player_reg);
    assign filled_nz = (slots_filled_reg != '0);
    assign full      = (slots_filled_reg >= FW'(SLOT_COUNT));
    assign enter     = ((hs_reg == HS_IDENTITY) || (hs_reg == HS_RUMBLE))
                       && (player_reg == STREAM_PLAYER);
    assign stream    = match && filled_nz && (enter || (hs_reg == HS_STREAM));
    assign eff_off   = enter ? '0 : read_offset_reg;
    assign next_ply  = (player_reg == 3'd1) ? 2'd3 : player_reg[1:0] - 2'd1;
    assign off_sum    = OXW'(eff_off) + OXW'(4);
    assign wr_off_inc = OXW'(write_offset_reg) + OXW'(1);
    assign rd_off     = OXW'(eff_off) + OXW'(cmd.rd_idx);
    assign rd_beyond  = (rd_off >= OXW'(COMMAND_BYTES));
    assign rd_addr = AW'(AW'(read_slot_reg) * AW'(COMMAND_BYTES)) + AW'(rd_off[OW-1:0]);
    assign wr_addr = AW'(AW'(write_slot_reg) * AW'(COMMAND_BYTES)) + AW'(write_offset_reg);
    assign sts.stream = stream;

    always_comb
    begin
        case (player_reg)
            3'd1:    pbit = 4'b0001;
            3'd2:    pbit = 4'b0010;
            3'd3:    pbit = 4'b0100;
            3'd4:    pbit = 4'b1000;
            default: pbit = 4'b0000;
        endcase
        seen_base = (hs_reg == HS_IDENTITY) ? 4'h0 : rumble_seen_reg;
        bits_base = (hs_reg == HS_IDENTITY) ? 4'h0 : rumble_bits_reg;
        seen_new  = seen_base | pbit;
        bits_new  = bits_base | (write_first_byte_reg[0] ? pbit : 4'h0);
    end

    always_comb
    begin
        write_slot_next      = write_slot_reg;
        read_slot_next       = read_slot_reg;
        slots_filled_next    = slots_filled_reg;
        write_offset_next    = write_offset_reg;
        read_offset_next     = read_offset_reg;
        expected_player_next = expected_player_reg;
        hs_next              = hs_reg;
        rumble_seen_next     = rumble_seen_reg;
        rumble_bits_next     = rumble_bits_reg;
        status_next    = STS_OK;
        complete_next  = 1'b0;
        kind_next      = SEND_NONE;
        word_out_next  = '0;
        crc_err_next   = 1'b0;
        val_err_next   = 1'b0;
        rep_valid_next = 1'b0;
        report_next    = '0;
        mem_we         = 1'b0;
        unique case (mode_reg)
            MODE_RESET:
            begin
                write_slot_next      = '0;
                read_slot_next       = '0;
                slots_filled_next    = '0;
                write_offset_next    = '0;
                read_offset_next     = '0;
                expected_player_next = RESET_PLAYER;
                hs_next              = HS_IDLE;
                rumble_seen_next     = '0;
                rumble_bits_next     = '0;
            end
            MODE_CHECK:
            begin
                if (full)
                    status_next = STS_FULL;
                else if (write_offset_reg != '0)
                    status_next = STS_PARTIAL;
            end
            MODE_BYTE:
            begin
                if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (wr_off_inc >= OXW'(COMMAND_BYTES))
                    begin
                        write_offset_next = '0;
                        write_slot_next   = (write_slot_reg == SW'(SLOT_COUNT - 1)) ?
                                            '0 : write_slot_reg + SW'(1);
                        slots_filled_next = slots_filled_reg + FW'(1);
                        complete_next     = 1'b1;
                    end
                    else
                    begin
                        write_offset_next = wr_off_inc[OW-1:0];
                    end
                end
            end
            MODE_IDENTITY:
            begin
                hs_next              = HS_IDENTITY;
                expected_player_next = next_ply;
            end
            MODE_CTL_RESET:
            begin
                hs_next              = HS_IDLE;
                expected_player_next = next_ply;
            end
            MODE_POLL:
            begin
                expected_player_next = next_ply;
                if (stream)
                begin
                    kind_next     = SEND_CMD;
                    word_out_next = word_reg;
                    if (off_sum >= OXW'(COMMAND_BYTES))
                    begin
                        hs_next           = HS_IDLE;
                        read_offset_next  = '0;
                        read_slot_next    = (read_slot_reg == SW'(SLOT_COUNT - 1)) ?
                                            '0 : read_slot_reg + SW'(1);
                        slots_filled_next = slots_filled_reg - FW'(1);
                    end
                    else
                    begin
                        hs_next          = HS_STREAM;
                        read_offset_next = off_sum[OW-1:0];
                    end
                end
                else
                begin
                    hs_next   = HS_IDLE;
                    kind_next = SEND_DEFAULT;
                end
            end
            MODE_ACC_READ:
            begin
                if (request_length_reg != READ_LENGTH)
                begin
                    status_next = STS_BAD_READ;
                end
                else
                begin
                    crc_err_next     = !address_crc_ok_reg;
                    rumble_seen_next = '0;
                    if (accessory_address_reg[15:5] == PROBE_ADDRESS)
                        kind_next = SEND_PROBE;
                end
            end
            MODE_ACC_WRITE:
            begin
                if (request_length_reg != WRITE_LENGTH)
                begin
                    status_next = STS_BAD_WRITE;
                end
                else
                begin
                    crc_err_next = !address_crc_ok_reg;
                    kind_next    = SEND_ACK;
                    if (accessory_address_reg[15:5] == RUMBLE_ADDRESS)
                    begin
                        val_err_next     = |(write_first_byte_reg & RUMBLE_EXTRA_MASK);
                        rumble_seen_next = seen_new;
                        rumble_bits_next = bits_new;
                        if (hs_reg == HS_IDENTITY)
                            hs_next = HS_RUMBLE;
                        if (seen_new == REPORT_SET)
                        begin
                            rep_valid_next = 1'b1;
                            report_next    = bits_new;
                        end
                    end
                    else
                    begin
                        rumble_seen_next = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg      <= '0;
            read_slot_reg       <= '0;
            slots_filled_reg    <= '0;
            write_offset_reg    <= '0;
            read_offset_reg     <= '0;
            expected_player_reg <= RESET_PLAYER;
            hs_reg              <= HS_IDLE;
            rumble_seen_reg     <= '0;
            rumble_bits_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            write_slot_reg      <= write_slot_next;
            read_slot_reg       <= read_slot_next;
            slots_filled_reg    <= slots_filled_next;
            write_offset_reg    <= write_offset_next;
            read_offset_reg     <= read_offset_next;
            expected_player_reg <= expected_player_next;
            hs_reg              <= hs_next;
            rumble_seen_reg     <= rumble_seen_next;
            rumble_bits_reg     <= rumble_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
            mem[wr_addr] <= host_byte_reg;
        if (cmd.rd_issue)
        begin
            rdata_reg  <= mem[rd_addr];
            beyond_reg <= rd_beyond;
        end
        if (cmd.capture)
            word_reg <= {word_reg[23:0], beyond_reg ? 8'h00 : rdata_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            complete_reg  <= complete_next;
            kind_reg      <= kind_next;
            word_out_reg  <= word_out_next;
            crc_err_reg   <= crc_err_next;
            val_err_reg   <= val_err_next;
            rep_valid_reg <= rep_valid_next;
            report_reg    <= report_next;
        end
    end

    assign status              = status_reg;
    assign command_complete    = complete_reg;
    assign send_kind           = kind_reg;
    assign send_word           = word_out_reg;
    assign address_crc_error   = crc_err_reg;
    assign rumble_value_error  = val_err_reg;
    assign rumble_report_valid = rep_valid_reg;
    assign rumble_report       = report_reg;

endmodule

// ----- hw/rtl/controller_port_command_tunnel.sv -----
// An accepted item is loaded into input registers; its result is registered at commit,
// once the output is free. A streaming poll first reads its four command bytes,
// one per cycle, from the single store read port. No new item is taken until the
// current one commits, but one is taken while a result waits in the output register.
// rst_n (asynchronous, active low) clears control state and ring pointers;
// the command store holds no reset value and is valid only where written.
module controller_port_command_tunnel
    import cpct_pkg::*;
#(
    parameter int SLOT_COUNT    = 16,
    parameter int COMMAND_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [2:0]  player,
    input  logic [7:0]  host_byte,
    input  logic [6:0]  request_length,
    input  logic [15:0] accessory_address,
    input  logic        address_crc_ok,
    input  logic [7:0]  write_first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        command_complete,
    output logic [2:0]  send_kind,
    output logic [31:0] send_word,
    output logic        address_crc_error,
    output logic        rumble_value_error,
    output logic        rumble_report_valid,
    output logic [3:0]  rumble_report
);

    cpct_cmd_t cmd;
    cpct_sts_t sts;

    cpct_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpct_dp #(
        .SLOT_COUNT    (SLOT_COUNT),
        .COMMAND_BYTES (COMMAND_BYTES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .mode                (mode),
        .player              (player),
        .host_byte           (host_byte),
        .request_length      (request_length),
        .accessory_address   (accessory_address),
        .address_crc_ok      (address_crc_ok),
        .write_first_byte    (write_first_byte),
        .status              (status),
        .command_complete    (command_complete),
        .send_kind           (send_kind),
        .send_word           (send_word),
        .address_crc_error   (address_crc_error),
        .rumble_value_error  (rumble_value_error),
        .rumble_report_valid (rumble_report_valid),
        .rumble_report       (rumble_report)
    );

endmodule

// ----- hw/rtl/cpct_chk.sv -----
module cpct_chk
    import cpct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        command_complete,
    input logic [2:0]  send_kind,
    input logic [31:0] send_word,
    input logic        rumble_report_valid,
    input logic [3:0]  rumble_report
);

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_word) && $stable(status))
        else $error("stalled item changed");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (send_kind != SEND_CMD) |-> send_word == '0)
        else $error("send_word set without command bytes");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rumble_report_valid |-> rumble_report == '0)
        else $error("rumble_report set without report");

    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_complete |-> (status == STS_OK) && (send_kind == SEND_NONE))
        else $error("completed command with other result");

endmodule

bind controller_port_command_tunnel cpct_chk u_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .command_complete    (command_complete),
    .send_kind           (send_kind),
    .send_word           (send_word),
    .rumble_report_valid (rumble_report_valid),
    .rumble_report       (rumble_report)
);
